[rtl/tcl_pkg.sv]
// Package for the text cursor layout unit: byte codes, configuration
// register indexes, reset values, shared types and the saturating add.
// No dependencies.
`default_nettype none

package tcl_pkg;

  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharDelete  = 8'h7F;
  localparam logic [4:0] ColourSel   = 5'b10000;  // bytes 128..135

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GLYPH_WIDTH  = 3'd0,
    REG_GLYPH_HEIGHT = 3'd1,
    REG_TAB_CELLS    = 3'd2,
    REG_SCREEN_WIDTH = 3'd3,
    REG_LEFT_MARGIN  = 3'd4,
    REG_RIGHT_MARGIN = 3'd5,
    REG_TOP_MARGIN   = 3'd6
  } cfg_reg_e;

  localparam logic [5:0]  GlyphWidthRst  = 6'd8;
  localparam logic [5:0]  GlyphHeightRst = 6'd8;
  localparam logic [3:0]  TabCellsRst    = 4'd4;
  localparam logic [11:0] ScreenWidthRst = 12'd1280;
  localparam logic [9:0]  MarginRst      = 10'd32;
  localparam logic [2:0]  ColourRst      = 3'd7;

  typedef struct packed {
    logic [5:0]  glyph_width;
    logic [5:0]  glyph_height;
    logic [3:0]  tab_cells;
    logic [11:0] screen_width;
    logic [9:0]  left_margin;
    logic [9:0]  right_margin;
    logic [9:0]  top_margin;
  } tcl_cfg_t;

  typedef struct packed {
    logic [12:0] x;
    logic [15:0] y;
    logic [2:0]  colour;
  } tcl_cursor_t;

  typedef struct packed {
    logic        emit;
    logic [12:0] glyph_x;
    logic [15:0] glyph_y;
    logic [6:0]  glyph_code;
    logic [2:0]  colour_index;
  } tcl_result_t;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [9:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {7'd0, b};
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

endpackage

`default_nettype wire

[rtl/tcl_step.sv]
// One layout step: decodes a text byte against the cursor state and the
// configuration, gives the next cursor state and the glyph request.
// Depends on tcl_pkg.
`default_nettype none

module tcl_step import tcl_pkg::*; (
  input  var logic [7:0]  text_byte_i,
  input  var tcl_cfg_t    cfg_i,
  input  var tcl_cursor_t cur_i,
  output tcl_cursor_t     nxt_o,
  output tcl_result_t     res_o
);

  logic        printable;
  logic        is_colour;
  logic [6:0]  cell_px;
  logic [9:0]  line_step;
  logic [10:0] tab_adv;
  logic [10:0] adv;
  logic [13:0] x_adv;
  logic [13:0] x1;
  logic [15:0] y1;
  logic [2:0]  colour_nxt;
  logic [15:0] y_nl;
  logic [14:0] x_next_cell;
  logic [10:0] margins;
  logic [13:0] usable;
  logic        wrap;

  assign printable = !text_byte_i[7] && (text_byte_i[6:5] != 2'b00)
                     && (text_byte_i != CharDelete);
  assign is_colour = (text_byte_i[7:3] == ColourSel);
  assign cell_px   = {1'b0, cfg_i.glyph_width} + 7'd1;
  assign line_step = {4'd0, cfg_i.glyph_height} + 10'd1;
  assign tab_adv   = {7'd0, cfg_i.tab_cells} * {4'd0, cell_px};
  assign adv       = (text_byte_i == CharTab) ? tab_adv : {4'd0, cell_px};
  assign x_adv     = {1'b0, cur_i.x} + {3'd0, adv};
  assign y_nl      = sat_add16(cur_i.y, line_step);

  always_comb begin
    x1 = {1'b0, cur_i.x};
    y1 = cur_i.y;
    colour_nxt = cur_i.colour;
    if (text_byte_i == CharNewline) begin
      x1 = '0;
      y1 = y_nl;
    end else if (text_byte_i[7]) begin
      if (is_colour) begin
        colour_nxt = text_byte_i[2:0];
      end
    end else begin
      x1 = x_adv;
    end
  end

  assign x_next_cell = {1'b0, x1} + {8'd0, cell_px};
  assign margins     = {1'b0, cfg_i.left_margin} + {1'b0, cfg_i.right_margin};
  assign usable      = {2'd0, cfg_i.screen_width} - {3'd0, margins};
  assign wrap        = $signed({1'b0, x_next_cell}) >= $signed({{2{usable[13]}}, usable});

  assign nxt_o.x      = wrap ? 13'd0 : x1[12:0];
  assign nxt_o.y      = wrap ? sat_add16(y1, line_step) : y1;
  assign nxt_o.colour = colour_nxt;

  assign res_o.emit         = printable;
  assign res_o.glyph_x      = cur_i.x + {3'd0, cfg_i.left_margin};
  assign res_o.glyph_y      = sat_add16(cur_i.y, cfg_i.top_margin);
  assign res_o.glyph_code   = text_byte_i[6:0];
  assign res_o.colour_index = cur_i.colour;

endmodule

`default_nettype wire

[rtl/text_cursor_layout_unit.sv]
// Text cursor layout unit: top level with configuration registers, input
// register, cursor state and result register. Depends on tcl_pkg, tcl_step.
//
// Takes one text byte per cycle and keeps a pixel cursor and a colour. Each
// printable byte (0x20..0x7E) gives one glyph request; other bytes may move the
// cursor or change the colour and give none. From input request to result a
// byte passes the input register, where the cursor update is done by a
// single add/compare step, and then the result register.
// Sustained rate is one byte per cycle, held back only by backpressure on
// the result side. Write configuration only while the unit is idle.
`default_nettype none

module text_cursor_layout_unit import tcl_pkg::*; (
  input  var logic                 clk_i,
  input  var logic                 rst_ni,
  input  var logic                 cfg_we_i,
  input  var logic [CfgIdxW-1:0]   cfg_idx_i,
  input  var logic [CfgDataW-1:0]  cfg_data_i,
  input  var logic                 s_axis_tvalid,
  output logic                     s_axis_tready,
  input  var logic [TdataInW-1:0]  s_axis_tdata,   // [7:0] text_byte
  output logic                     m_axis_tvalid,
  input  var logic                 m_axis_tready,
  output logic [TdataOutW-1:0]     m_axis_tdata    // [12:0] glyph_x, [28:13] glyph_y,
                                                   // [35:29] glyph_code,
                                                   // [38:36] colour_index, [39] zero
);

  tcl_cfg_t    cfg_q;
  tcl_cursor_t cur_q, cur_d;
  tcl_result_t res;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        out_valid_q;
  logic [38:0] out_data_q;
  logic        step_go;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_width  <= GlyphWidthRst;
      cfg_q.glyph_height <= GlyphHeightRst;
      cfg_q.tab_cells    <= TabCellsRst;
      cfg_q.screen_width <= ScreenWidthRst;
      cfg_q.left_margin  <= MarginRst;
      cfg_q.right_margin <= MarginRst;
      cfg_q.top_margin   <= MarginRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= cfg_data_i[5:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= cfg_data_i[5:0];
        REG_TAB_CELLS:    cfg_q.tab_cells    <= cfg_data_i[3:0];
        REG_SCREEN_WIDTH: cfg_q.screen_width <= cfg_data_i;
        REG_LEFT_MARGIN:  cfg_q.left_margin  <= cfg_data_i[9:0];
        REG_RIGHT_MARGIN: cfg_q.right_margin <= cfg_data_i[9:0];
        REG_TOP_MARGIN:   cfg_q.top_margin   <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  tcl_step u_step (
    .text_byte_i (in_byte_q),
    .cfg_i       (cfg_q),
    .cur_i       (cur_q),
    .nxt_o       (cur_d),
    .res_o       (res)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_go       = in_valid_q && (!res.emit || out_free);
  assign s_axis_tready = !in_valid_q || step_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.x      <= '0;
      cur_q.y      <= '0;
      cur_q.colour <= ColourRst;
    end else if (step_go) begin
      cur_q <= cur_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step_go && res.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && res.emit) begin
      out_data_q <= {res.colour_index, res.glyph_code, res.glyph_y, res.glyph_x};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_data_q};

  // check that cursor x stays below 4095 after every step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q.x < 13'd4095)
    else $error("cursor x out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[35:29] >= 7'h20) && (m_axis_tdata[35:29] != 7'h7F))
    else $error("non-printable glyph request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:0] <= 13'd5117)
    else $error("glyph x beyond reachable range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && (in_byte_q[7:3] != ColourSel)) |=> $stable(cur_q.colour))
    else $error("colour changed by non-colour byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step_go) |=> $stable(cur_q) && $stable(in_byte_q))
    else $error("stalled step changed state");

endmodule

`default_nettype wire
